/* src/rqfs_pkg.sv */
package rqfs_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned START_W    = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned OFFSET_W   = 40;

  localparam logic [9:0]  MIN_SEG_LEN_RESET = 10'd30;
  localparam logic [7:0]  LOW_QUAL_RESET    = 8'd53;
  localparam logic [10:0] QUAL_DIV_RESET    = 11'd10;
  localparam logic [7:0]  SEPARATOR_RESET   = 8'd78;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SEG_LEN = 2'd0,
    CFG_LOW_QUAL    = 2'd1,
    CFG_QUAL_DIV    = 2'd2,
    CFG_SEPARATOR   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_SEGMENT     = 2'd0,
    KIND_ACCEPT      = 2'd1,
    KIND_LOW_QUALITY = 2'd2,
    KIND_OVERFLOW    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MUL,
    ST_DEC,
    ST_SEG,
    ST_STAT
  } state_e;

  typedef struct packed {
    logic [9:0]  min_segment_length;
    logic [7:0]  low_quality_symbol;
    logic [10:0] quality_divisor;
    logic [7:0]  separator_symbol;
  } cfg_t;

  typedef struct packed {
    logic [7:0] base_symbol;
    logic [7:0] quality_symbol;
    logic       end_of_read;
  } in_item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [START_W-1:0]    segment_start;
    logic [LEN_W-1:0]      segment_length;
    logic [OFFSET_W-1:0]   concat_offset;
    logic [LEN_W-1:0]      longest_segment;
    logic                  last_result;
  } out_item_t;

endpackage

/* src/rqfs_ram.sv */
module rqfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rqfs_scan.sv */
// Per-base front end: position, piece tracking, low-quality count and
// segment store writes.
module rqfs_scan #(
  parameter int unsigned MAX_BASES    = 1024,
  parameter int unsigned MAX_SEGMENTS = 32,
  parameter int unsigned POS_W = $clog2(MAX_BASES + 1),
  parameter int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1),
  parameter int unsigned AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  rqfs_pkg::in_item_t       item_i,
  input  rqfs_pkg::cfg_t           cfg_i,
  input  logic                     clear_i,
  output logic                     we_o,
  output logic [AW-1:0]            waddr_o,
  output logic [rqfs_pkg::START_W+POS_W-1:0] wdata_o,
  output logic [POS_W-1:0]         pos_o,
  output logic [POS_W-1:0]         low_cnt_o,
  output logic [CNT_W-1:0]         seg_cnt_o,
  output logic                     overflow_o,
  output logic [POS_W-1:0]         read_max_o
);

  localparam int unsigned CMP_W = POS_W + 10;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] piece_start_q, piece_start_d;
  logic [POS_W-1:0] low_cnt_q, low_cnt_d;
  logic [CNT_W-1:0] seg_cnt_q, seg_cnt_d;
  logic             overflow_q, overflow_d;
  logic [POS_W-1:0] read_max_q, read_max_d;

  logic             base_ok, is_sep, is_low, full, keep, cand_vld;
  logic [POS_W-1:0] pos_nxt, sep_len, tail_len, piece_len;

  always_comb begin
    base_ok  = pos_q < POS_W'(MAX_BASES);
    is_sep   = base_ok && (item_i.base_symbol == cfg_i.separator_symbol);
    is_low   = base_ok && (item_i.quality_symbol < cfg_i.low_quality_symbol);
    pos_nxt  = base_ok ? pos_q + POS_W'(1) : pos_q;
    sep_len  = (pos_q >= piece_start_q) ? pos_q - piece_start_q : '0;
    tail_len = (pos_nxt >= piece_start_q) ? pos_nxt - piece_start_q : '0;
    // a separator on the last base leaves an empty tail, so one write at most
    piece_len = is_sep ? sep_len : tail_len;
    keep = fire_i && (is_sep || item_i.end_of_read) && (piece_len != '0) &&
           (CMP_W'(piece_len) >= CMP_W'(cfg_i.min_segment_length));
    full = seg_cnt_q >= CNT_W'(MAX_SEGMENTS);
    we_o = keep && !full;
    // the tail always takes part in the longest segment
    cand_vld = we_o || (fire_i && item_i.end_of_read && !is_sep);

    pos_d         = pos_q;
    piece_start_d = piece_start_q;
    low_cnt_d     = low_cnt_q;
    seg_cnt_d     = seg_cnt_q;
    overflow_d    = overflow_q;
    read_max_d    = read_max_q;
    if (clear_i) begin
      pos_d         = '0;
      piece_start_d = '0;
      low_cnt_d     = '0;
      seg_cnt_d     = '0;
      overflow_d    = 1'b0;
      read_max_d    = '0;
    end else if (fire_i) begin
      pos_d = pos_nxt;
      if (is_sep) begin
        piece_start_d = pos_q + POS_W'(1);
      end
      if (is_low) begin
        low_cnt_d = low_cnt_q + POS_W'(1);
      end
      if (we_o) begin
        seg_cnt_d = seg_cnt_q + CNT_W'(1);
      end
      if (!base_ok || (keep && full)) begin
        overflow_d = 1'b1;
      end
      if (cand_vld && (piece_len > read_max_q)) begin
        read_max_d = piece_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      piece_start_q <= '0;
      low_cnt_q     <= '0;
      seg_cnt_q     <= '0;
      overflow_q    <= 1'b0;
      read_max_q    <= '0;
    end else begin
      pos_q         <= pos_d;
      piece_start_q <= piece_start_d;
      low_cnt_q     <= low_cnt_d;
      seg_cnt_q     <= seg_cnt_d;
      overflow_q    <= overflow_d;
      read_max_q    <= read_max_d;
    end
  end

  assign waddr_o    = seg_cnt_q[AW-1:0];
  assign wdata_o    = {rqfs_pkg::START_W'(piece_start_q), piece_len};
  assign pos_o      = pos_q;
  assign low_cnt_o  = low_cnt_q;
  assign seg_cnt_o  = seg_cnt_q;
  assign overflow_o = overflow_q;
  assign read_max_o = read_max_q;

endmodule

/* src/rqfs_emit.sv */
// End-of-read sequencer: quality verdict, segment readout from the store,
// running totals and the output register.
module rqfs_emit #(
  parameter int unsigned MAX_BASES    = 1024,
  parameter int unsigned MAX_SEGMENTS = 32,
  parameter int unsigned POS_W = $clog2(MAX_BASES + 1),
  parameter int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1),
  parameter int unsigned AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic                     end_of_read_i,
  input  rqfs_pkg::cfg_t           cfg_i,
  input  logic [POS_W-1:0]         pos_i,
  input  logic [POS_W-1:0]         low_cnt_i,
  input  logic [CNT_W-1:0]         seg_cnt_i,
  input  logic                     overflow_i,
  input  logic [POS_W-1:0]         read_max_i,
  output logic                     rd_en_o,
  output logic [AW-1:0]            rd_addr_o,
  input  logic [rqfs_pkg::START_W+POS_W-1:0] rd_data_i,
  output logic                     in_ready_o,
  output logic                     clear_o,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output rqfs_pkg::out_item_t      out_item_o
);

  localparam int unsigned PROD_W = POS_W + 11;

  rqfs_pkg::state_e    state_q, state_d;
  rqfs_pkg::kind_e     kind_q, kind_d;
  rqfs_pkg::out_item_t out_item_q, load_item;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [CNT_W-1:0]    idx_q, idx_d, idx_nxt;
  logic [rqfs_pkg::OFFSET_W-1:0] total_q, total_d;
  logic [POS_W-1:0]    longest_q, longest_d, seg_len;
  logic                out_valid_q, can_load, load;

  assign can_load = !out_valid_q || !out_stall_i;
  assign idx_nxt  = idx_q + CNT_W'(1);
  assign seg_len  = rd_data_i[POS_W-1:0];
  assign prod_d   = PROD_W'(low_cnt_i) * PROD_W'(cfg_i.quality_divisor);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rqfs_pkg::ST_RUN: begin
        if (fire_i && end_of_read_i) begin
          state_d = rqfs_pkg::ST_MUL;
        end
      end
      rqfs_pkg::ST_MUL: state_d = rqfs_pkg::ST_DEC;
      rqfs_pkg::ST_DEC: begin
        if (!overflow_i && (prod_q <= PROD_W'(pos_i)) && (seg_cnt_i != '0)) begin
          state_d = rqfs_pkg::ST_SEG;
        end else begin
          state_d = rqfs_pkg::ST_STAT;
        end
      end
      rqfs_pkg::ST_SEG: begin
        if (can_load && (idx_nxt == seg_cnt_i)) begin
          state_d = rqfs_pkg::ST_STAT;
        end
      end
      rqfs_pkg::ST_STAT: begin
        if (can_load) begin
          state_d = rqfs_pkg::ST_RUN;
        end
      end
      default: state_d = rqfs_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    clear_o    = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;
    load       = 1'b0;
    load_item  = '0;
    kind_d     = kind_q;
    idx_d      = idx_q;
    total_d    = total_q;
    longest_d  = longest_q;
    case (state_q)
      rqfs_pkg::ST_RUN: in_ready_o = 1'b1;
      rqfs_pkg::ST_MUL: ;
      rqfs_pkg::ST_DEC: begin
        if (overflow_i) begin
          kind_d = rqfs_pkg::KIND_OVERFLOW;
        end else if (prod_q > PROD_W'(pos_i)) begin
          kind_d = rqfs_pkg::KIND_LOW_QUALITY;
        end else begin
          kind_d = rqfs_pkg::KIND_ACCEPT;
          if (read_max_i > longest_q) begin
            longest_d = read_max_i;
          end
          rd_en_o = 1'b1;
          idx_d   = '0;
        end
      end
      rqfs_pkg::ST_SEG: begin
        if (can_load) begin
          load                     = 1'b1;
          load_item.kind           = rqfs_pkg::KIND_SEGMENT;
          load_item.segment_start  = rd_data_i[rqfs_pkg::START_W+POS_W-1:POS_W];
          load_item.segment_length = rqfs_pkg::LEN_W'(seg_len);
          load_item.concat_offset  = total_q;
          load_item.longest_segment = rqfs_pkg::LEN_W'(longest_q);
          load_item.last_result    = 1'b0;
          total_d = total_q + rqfs_pkg::OFFSET_W'(seg_len) + rqfs_pkg::OFFSET_W'(1);
          idx_d   = idx_nxt;
          // prefetch the next entry while this beat is loaded
          if (idx_nxt != seg_cnt_i) begin
            rd_en_o   = 1'b1;
            rd_addr_o = idx_nxt[AW-1:0];
          end
        end
      end
      rqfs_pkg::ST_STAT: begin
        if (can_load) begin
          load                      = 1'b1;
          clear_o                   = 1'b1;
          load_item.kind            = kind_q;
          load_item.concat_offset   = total_q;
          load_item.longest_segment = rqfs_pkg::LEN_W'(longest_q);
          load_item.last_result     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rqfs_pkg::ST_RUN;
      idx_q       <= '0;
      total_q     <= '0;
      longest_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      longest_q   <= longest_d;
      out_valid_q <= load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    kind_q <= kind_d;
    if (load) begin
      out_item_q <= load_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* src/read_quality_filter_and_splitter_top.sv */
// Bases are taken one per cycle while a read streams in.
// After the last base of a read the input stalls through the quality multiply,
// the verdict, one store read per segment beat sent (none for a rejected read)
// and then the status beat; output stalls add to this.
// The first result enters the output register after the multiply and verdict states.
// Reset clears counters, totals and config to defaults; the segment store is not cleared.
module read_quality_filter_and_splitter_top #(
  parameter int unsigned MAX_BASES    = 1024,
  parameter int unsigned MAX_SEGMENTS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  rqfs_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output rqfs_pkg::out_item_t                out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rqfs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rqfs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned POS_W = $clog2(MAX_BASES + 1);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned ENT_W = rqfs_pkg::START_W + POS_W;

  rqfs_pkg::cfg_t   cfg_q, cfg_d;
  logic             in_ready, fire, clear;
  logic             we, rd_en, overflow;
  logic [AW-1:0]    waddr, rd_addr;
  logic [ENT_W-1:0] wdata, rd_data;
  logic [POS_W-1:0] pos, low_cnt, read_max;
  logic [CNT_W-1:0] seg_cnt;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !in_ready;
  assign fire        = in_valid_i && in_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rqfs_pkg::CFG_MIN_SEG_LEN: cfg_d.min_segment_length = cfg_data_i[9:0];
        rqfs_pkg::CFG_LOW_QUAL:    cfg_d.low_quality_symbol = cfg_data_i[7:0];
        rqfs_pkg::CFG_QUAL_DIV:    cfg_d.quality_divisor    = cfg_data_i;
        rqfs_pkg::CFG_SEPARATOR:   cfg_d.separator_symbol   = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_segment_length <= rqfs_pkg::MIN_SEG_LEN_RESET;
      cfg_q.low_quality_symbol <= rqfs_pkg::LOW_QUAL_RESET;
      cfg_q.quality_divisor    <= rqfs_pkg::QUAL_DIV_RESET;
      cfg_q.separator_symbol   <= rqfs_pkg::SEPARATOR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rqfs_scan #(
    .MAX_BASES   (MAX_BASES),
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .POS_W       (POS_W),
    .CNT_W       (CNT_W),
    .AW          (AW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_item_i),
    .cfg_i      (cfg_q),
    .clear_i    (clear),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .pos_o      (pos),
    .low_cnt_o  (low_cnt),
    .seg_cnt_o  (seg_cnt),
    .overflow_o (overflow),
    .read_max_o (read_max)
  );

  // writes only happen while bases stream in, reads only after the read ends
  rqfs_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_SEGMENTS),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  rqfs_emit #(
    .MAX_BASES   (MAX_BASES),
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .POS_W       (POS_W),
    .CNT_W       (CNT_W),
    .AW          (AW)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .end_of_read_i(in_item_i.end_of_read),
    .cfg_i        (cfg_q),
    .pos_i        (pos),
    .low_cnt_i    (low_cnt),
    .seg_cnt_i    (seg_cnt),
    .overflow_i   (overflow),
    .read_max_i   (read_max),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .in_ready_o   (in_ready),
    .clear_o      (clear),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o)
  );

endmodule
